// ----- rtl/pltr_pkg.sv -----
package pltr_pkg;

    // opcode values of an input item
    localparam logic OP_MAP    = 1'b0;
    localparam logic OP_APPEND = 1'b1;

    // width of the time fields, Q16.16 style signed words
    localparam int TIME_W = 32;

    // entries of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_COVER = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // what the back end does with a queued command
    typedef enum logic [1:0] {
        ACT_REPLY = 2'd0,
        ACT_STORE = 2'd1,
        ACT_SCAN  = 2'd2
    } t_act;

    typedef struct packed {
        logic signed [TIME_W-1:0] old_start;
        logic signed [TIME_W-1:0] old_end;
        logic signed [TIME_W-1:0] target_start;
        logic signed [TIME_W-1:0] target_end;
    } t_seg;

    typedef struct packed {
        t_act                     act;
        t_status                  status;
        logic signed [TIME_W-1:0] time_val;
        logic [3:0]               sample_id;
        t_seg                     seg;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_CMP,
        BS_DIV,
        BS_MUL,
        BS_FIN,
        BS_OUT
    } t_back_state;

endpackage

// ----- rtl/pltr_front.sv -----
module pltr_front #(
    parameter int MAX_SAMPLES  = 16,
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_opcode,
    input  logic [3:0]                             i_sample_id,
    input  logic signed [pltr_pkg::TIME_W-1:0]     i_time_in,
    input  logic signed [pltr_pkg::TIME_W-1:0]     i_old_start,
    input  logic signed [pltr_pkg::TIME_W-1:0]     i_old_end,
    input  logic signed [pltr_pkg::TIME_W-1:0]     i_target_start,
    input  logic signed [pltr_pkg::TIME_W-1:0]     i_target_end,
    input  logic                                   i_q_ready,
    output logic                                   o_push,
    output pltr_pkg::t_cmd                         o_cmd,
    output logic [$clog2(MAX_SEGMENTS+1)-1:0]      o_cnt
);

    localparam int SID_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    logic [CNT_W-1:0] r_count [MAX_SAMPLES];
    logic [SID_W-1:0] sid_idx;
    logic             in_range;
    logic [CNT_W-1:0] cnt_cur;
    logic             list_full;
    logic             do_store;

    assign sid_idx   = SID_W'(i_sample_id);
    assign in_range  = (32'(i_sample_id) < MAX_SAMPLES);
    assign cnt_cur   = in_range ? r_count[sid_idx] : '0;
    assign list_full = (cnt_cur >= CNT_W'(MAX_SEGMENTS));

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid && i_q_ready;
    assign do_store   = o_push && (i_opcode == pltr_pkg::OP_APPEND) && in_range && !list_full;

    // classify the item
    always_comb begin
        o_cmd.seg.old_start    = i_old_start;
        o_cmd.seg.old_end      = i_old_end;
        o_cmd.seg.target_start = i_target_start;
        o_cmd.seg.target_end   = i_target_end;
        o_cmd.sample_id        = i_sample_id;
        o_cnt                  = cnt_cur;
        if (i_opcode == pltr_pkg::OP_APPEND) begin
            o_cmd.time_val = '0;
            if (!in_range || list_full) begin
                o_cmd.act    = pltr_pkg::ACT_REPLY;
                o_cmd.status = pltr_pkg::ST_FULL;
            end else begin
                o_cmd.act    = pltr_pkg::ACT_STORE;
                o_cmd.status = pltr_pkg::ST_DONE;
            end
        end else begin
            o_cmd.time_val = i_time_in;
            if (!in_range || (cnt_cur == '0)) begin
                o_cmd.act    = pltr_pkg::ACT_REPLY;
                o_cmd.status = pltr_pkg::ST_EMPTY;
            end else begin
                o_cmd.act    = pltr_pkg::ACT_SCAN;
                o_cmd.status = pltr_pkg::ST_NO_COVER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '{default: '0};
        end else if (do_store) begin
            r_count[sid_idx] <= cnt_cur + 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_range |-> (cnt_cur <= CNT_W'(MAX_SEGMENTS)))
        else $error("segment count above list size");

endmodule

// ----- rtl/pltr_queue.sv -----
module pltr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_data [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_fill != FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_data[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/pltr_back.sv -----
module pltr_back #(
    parameter int MAX_SAMPLES  = 16,
    parameter int MAX_SEGMENTS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_valid,
    output logic                                   o_q_pop,
    input  pltr_pkg::t_cmd                         i_q_cmd,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0]      i_q_cnt,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pltr_pkg::TIME_W-1:0]     o_time_out,
    output logic [1:0]                             o_status
);

    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int DEPTH  = MAX_SAMPLES * MAX_SEGMENTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int STEP_W = $clog2(FRAC_BITS + 1);
    localparam int PW     = 33 + FRAC_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    pltr_pkg::t_back_state r_state, n_state;

    pltr_pkg::t_seg   r_mem [DEPTH];
    pltr_pkg::t_seg   r_rd_data;

    pltr_pkg::t_cmd   r_cmd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_idx;
    logic [31:0]      r_rem;
    logic [31:0]      r_d;
    logic [Q_W-1:0]   r_q;
    logic [STEP_W-1:0] r_step;
    logic [31:0]      r_mag;
    logic             r_neg;
    logic signed [31:0] r_ts;
    logic [PW-1:0]    r_prod;
    logic signed [31:0] r_res_time;
    pltr_pkg::t_status r_res_status;
    logic             r_out_valid;
    logic signed [31:0] r_out_time;
    pltr_pkg::t_status r_out_status;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic              out_load;

    logic              seg_hit;
    logic              seg_zero;
    logic [31:0]       seg_d;
    logic [31:0]       seg_n;
    logic signed [32:0] seg_dlt;
    logic [CNT_W-1:0]  idx_nx;
    logic              div_done;
    logic [32:0]       div_tmp;
    logic              div_ge;
    logic [PW-1:0]     rnd;
    logic [32:0]       rmag;
    logic signed [33:0] res_wide;
    logic signed [31:0] res_sat;

    // segment compare
    assign seg_hit  = (r_cmd.time_val >= r_rd_data.old_start) &&
                      (r_cmd.time_val <= r_rd_data.old_end);
    assign seg_d    = 32'(r_rd_data.old_end - r_rd_data.old_start);
    assign seg_n    = 32'(r_cmd.time_val - r_rd_data.old_start);
    assign seg_zero = (seg_d == '0);
    assign seg_dlt  = {r_rd_data.target_end[31], r_rd_data.target_end} -
                      {r_rd_data.target_start[31], r_rd_data.target_start};
    assign idx_nx   = r_idx + 1'b1;

    // one quotient bit per cycle, integer bit first
    assign div_done = (r_step == STEP_W'(FRAC_BITS));
    assign div_tmp  = (r_step == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign div_ge   = (div_tmp >= {1'b0, r_d});

    // round half away from zero on the magnitude, then saturate
    assign rnd      = r_prod + HALF;
    assign rmag     = rnd[FRAC_BITS +: 33];
    assign res_wide = r_neg ? ({{2{r_ts[31]}}, r_ts} - $signed({1'b0, rmag}))
                            : ({{2{r_ts[31]}}, r_ts} + $signed({1'b0, rmag}));
    always_comb begin
        if ((res_wide[33:31] == 3'b000) || (res_wide[33:31] == 3'b111)) begin
            res_sat = res_wide[31:0];
        end else if (res_wide[33]) begin
            res_sat = {1'b1, 31'd0};
        end else begin
            res_sat = {1'b0, {31{1'b1}}};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pltr_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_cmd.act == pltr_pkg::ACT_SCAN) ? pltr_pkg::BS_READ
                                                                   : pltr_pkg::BS_OUT;
                end
            end
            pltr_pkg::BS_READ: n_state = pltr_pkg::BS_CMP;
            pltr_pkg::BS_CMP: begin
                if (seg_hit) begin
                    n_state = seg_zero ? pltr_pkg::BS_OUT : pltr_pkg::BS_DIV;
                end else begin
                    n_state = (idx_nx == r_cnt) ? pltr_pkg::BS_OUT : pltr_pkg::BS_READ;
                end
            end
            pltr_pkg::BS_DIV: begin
                if (div_done) begin
                    n_state = pltr_pkg::BS_MUL;
                end
            end
            pltr_pkg::BS_MUL: n_state = pltr_pkg::BS_FIN;
            pltr_pkg::BS_FIN: n_state = pltr_pkg::BS_OUT;
            pltr_pkg::BS_OUT: begin
                if (out_load) begin
                    n_state = pltr_pkg::BS_IDLE;
                end
            end
            default: n_state = pltr_pkg::BS_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop   = (r_state == pltr_pkg::BS_IDLE) && i_q_valid;
        mem_we    = o_q_pop && (i_q_cmd.act == pltr_pkg::ACT_STORE);
        mem_waddr = ADDR_W'(32'(i_q_cmd.sample_id) * MAX_SEGMENTS + 32'(i_q_cnt));
        mem_raddr = ADDR_W'(32'(r_cmd.sample_id) * MAX_SEGMENTS + 32'(r_idx));
        out_load  = (r_state == pltr_pkg::BS_OUT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_q_cmd.seg;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pltr_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            pltr_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    r_cmd        <= i_q_cmd;
                    r_cnt        <= i_q_cnt;
                    r_idx        <= '0;
                    r_res_time   <= i_q_cmd.time_val;
                    r_res_status <= i_q_cmd.status;
                end
            end
            pltr_pkg::BS_CMP: begin
                r_idx  <= idx_nx;
                r_d    <= seg_d;
                r_rem  <= seg_n;
                r_ts   <= r_rd_data.target_start;
                r_neg  <= seg_dlt[32];
                r_mag  <= seg_dlt[32] ? 32'(-seg_dlt) : seg_dlt[31:0];
                r_q    <= '0;
                r_step <= '0;
                if (seg_hit && seg_zero) begin
                    r_res_time   <= r_rd_data.target_start;
                    r_res_status <= pltr_pkg::ST_DONE;
                end
            end
            pltr_pkg::BS_DIV: begin
                r_rem  <= div_ge ? 32'(div_tmp - {1'b0, r_d}) : div_tmp[31:0];
                r_q    <= {r_q[Q_W-2:0], div_ge};
                r_step <= r_step + 1'b1;
            end
            pltr_pkg::BS_MUL: begin
                r_prod <= r_mag * r_q;
            end
            pltr_pkg::BS_FIN: begin
                r_res_time   <= res_sat;
                r_res_status <= pltr_pkg::ST_DONE;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_time   <= r_res_time;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_time_out  = r_out_time;
    assign o_status    = r_out_status;

    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pltr_pkg::BS_CMP) |-> (r_idx < r_cnt))
        else $error("scan index past segment count");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pltr_pkg::BS_READ) |-> (r_cnt != '0) && (r_cmd.act == pltr_pkg::ACT_SCAN))
        else $error("scan started on empty list");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pltr_pkg::BS_MUL) |-> (r_q <= (Q_W'(1) << FRAC_BITS)))
        else $error("fraction above one");

endmodule

// ----- rtl/piecewise_linear_time_remap_unit.sv -----
// piecewise linear time remap
// keeps up to MAX_SEGMENTS segments per sample (MAX_SAMPLES samples) and maps
// signed fixed-point times through the first segment that holds them
// input channel (i_in_valid / o_in_ready): opcode append stores one segment in
// the sample's list and answers status done or full with time 0; opcode map
// answers the mapped time, or the input time with no-cover or empty status
// output channel (o_out_valid / i_out_ready): exactly one result item per item
// front classifies items and keeps per-sample counts; a 2-entry command queue
// feeds the back end, which scans the segment memory and runs the divider
// a reply made by the front passes the queue, the back end's idle and output states
// and the output register; a map walks the segments in order until a hit or the end,
// and a hit on a segment of nonzero length then runs the divider, multiply and finish
// states; each segment takes a registered memory read, then a compare; the fraction
// comes from a bit-per-cycle divider
// the back end works on one item at a time; the queue takes up to two more
// a stalled receiver holds the output register and the back end waits on it,
// then the queue fills and o_in_ready drops
// reset clears segment counts; segment memory needs no clearing pass
module piecewise_linear_time_remap_unit #(
    parameter int MAX_SAMPLES  = 16,
    parameter int MAX_SEGMENTS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [3:0]         i_sample_id,
    input  logic signed [31:0] i_time_in,
    input  logic signed [31:0] i_old_start,
    input  logic signed [31:0] i_old_end,
    input  logic signed [31:0] i_target_start,
    input  logic signed [31:0] i_target_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_time_out,
    output logic [1:0]         o_status
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int QW    = $bits(pltr_pkg::t_cmd) + CNT_W;

    // front to queue
    logic             push;
    logic             q_ready;
    pltr_pkg::t_cmd   f_cmd;
    logic [CNT_W-1:0] f_cnt;
    logic [QW-1:0]    push_data;

    // queue to back
    logic             q_valid;
    logic             q_pop;
    logic [QW-1:0]    pop_data;
    pltr_pkg::t_cmd   q_cmd;
    logic [CNT_W-1:0] q_cnt;

    assign push_data = {f_cmd, f_cnt};
    assign q_cmd     = pltr_pkg::t_cmd'(pop_data[QW-1:CNT_W]);
    assign q_cnt     = pop_data[CNT_W-1:0];

    pltr_front #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_sample_id    (i_sample_id),
        .i_time_in      (i_time_in),
        .i_old_start    (i_old_start),
        .i_old_end      (i_old_end),
        .i_target_start (i_target_start),
        .i_target_end   (i_target_end),
        .i_q_ready      (q_ready),
        .o_push         (push),
        .o_cmd          (f_cmd),
        .o_cnt          (f_cnt)
    );

    pltr_queue #(
        .WIDTH (QW),
        .DEPTH (pltr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (pop_data)
    );

    pltr_back #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_cmd     (q_cmd),
        .i_q_cnt     (q_cnt),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_time_out  (o_time_out),
        .o_status    (o_status)
    );

endmodule
